>>> rtl/rmsp_pkg.sv
// package for the ramped multichannel soft pwm block
// constants, operation codes and types shared by the top level and the ramp unit
package rmsp_pkg;

   localparam int MotorSlots = 5;
   localparam int SlotBits   = 3;
   localparam int DutyBits   = 11;
   localparam int StepBits   = 8;
   localparam int GuardTicks = 100;
   localparam logic signed [DutyBits-1:0] DutyMax = 11'sd1000;
   localparam logic signed [DutyBits-1:0] DutyMin = -11'sd1000;

   typedef enum logic [1:0] {
      OP_SET_TARGET = 2'd0,
      OP_SET_NOW    = 2'd1,
      OP_TICK       = 2'd2,
      OP_COMPARE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_ACTIVE = 2'd0,
      CSR_BRIDGE = 2'd1
   } csr_type;

   typedef logic signed [DutyBits-1:0] duty_type;
   typedef logic [DutyBits-2:0] mag_type;

   // result of one ramp step for one slot
   typedef struct packed {
      duty_type cur;
      logic     dir_wr;
      logic     dir_a;
      logic     dir_b;
   } ramp_res_type;

   function automatic mag_type mag_of(input duty_type v);
      duty_type n;
      n = v[DutyBits-1] ? -v : v;
      return n[DutyBits-2:0];
   endfunction

endpackage

>>> rtl/rmsp_ramp.sv
// shared ramp unit: moves one slot's present duty one step toward its target
// depends on rmsp_pkg
module rmsp_ramp (
   input  rmsp_pkg::duty_type               cur,
   input  rmsp_pkg::duty_type               tgt,
   input  logic [rmsp_pkg::StepBits-1:0]    step,
   input  logic                             bridge,
   output rmsp_pkg::ramp_res_type           res
);
   import rmsp_pkg::*;

   logic signed [DutyBits+1:0] cw, tw, sw, up, dn;
   logic                      flip;

   always_comb begin
      cw = (DutyBits+2)'(cur);
      tw = (DutyBits+2)'(tgt);
      sw = (DutyBits+2)'({1'b0, step});
      up = cw + sw;
      dn = cw - sw;
      flip = bridge && (cur != '0) && ((cur > 0) != (tgt > 0));
      res.cur    = cur;
      res.dir_wr = 1'b0;
      res.dir_a  = 1'b0;
      res.dir_b  = 1'b0;
      if (cur != tgt) begin
         if (flip) begin
            // ramp towards zero before the sign may change
            if (sw >= (DutyBits+2)'({1'b0, mag_of(cur)})) res.cur = '0;
            else if (cur > 0) res.cur = dn[DutyBits-1:0];
            else res.cur = up[DutyBits-1:0];
            res.dir_wr = (res.cur == '0);
         end else begin
            if (cur < tgt) res.cur = (up > tw) ? tgt : up[DutyBits-1:0];
            else res.cur = (dn < tw) ? tgt : dn[DutyBits-1:0];
            res.dir_wr = 1'b1;
            res.dir_a  = res.cur > 0;
            res.dir_b  = res.cur < 0;
         end
      end
   end

endmodule

>>> rtl/ramped_multichannel_soft_pwm.sv
// Ramped multichannel soft pwm. A set request goes straight to the output state;
// a compare request passes the compare state, and the schedule state when it
// schedules a new edge; a period tick walks the slots one per cycle through the
// shared ramp unit, then runs the exchange sort one compare per cycle (no compare
// with fewer than two active slots) and schedules the next edge. The block takes no
// request while one is in work; a finished result sits in an output register,
// and a request that finishes while the previous result still waits holds there.
// depends on rmsp_pkg and rmsp_ramp
module ramped_multichannel_soft_pwm (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0], motor_select[4:2], value[20:5], timer_count[36:21], zeros
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pwm_levels[4:0], dir_a[9:5], dir_b[14:10], compare_value[30:15],
   // compare_update[31]
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import rmsp_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_RAMP  = 6'b000010,
      ST_SORT  = 6'b000100,
      ST_SCHED = 6'b001000,
      ST_CMP   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [MotorSlots-1:0] active_ff, bridge_ff, pwm_ff, dira_ff, dirb_ff;
   logic [StepBits-1:0]   step_ff [MotorSlots];
   duty_type              tgt_ff [MotorSlots];
   duty_type              cur_ff [MotorSlots];
   logic [SlotBits-1:0]   order_ff [MotorSlots];
   logic [SlotBits-1:0]   cnt_ff, pos_ff, i_ff, j_ff;
   logic [15:0]           cmp_ff, tcount_ff;
   logic                  upd_ff, rsp_valid_ff;
   logic [31:0]           rsp_data_ff;

   ramp_res_type          rres;
   logic [SlotBits-1:0]   ri;
   duty_type              sel_cur;
   logic [15:0]           edge_v, safe_v;
   logic                  pend;
   duty_type              clamped;
   logic signed [15:0]    vin;
   op_type                req_op;
   logic [SlotBits-1:0]   req_sel;
   logic                  rsp_load;

   assign ri = i_ff;
   rmsp_ramp u_ramp (
      .cur   (cur_ff[ri]),
      .tgt   (tgt_ff[ri]),
      .step  (step_ff[ri]),
      .bridge(bridge_ff[ri]),
      .res   (rres)
   );

   assign req_op  = op_type'(req_tdata[1:0]);
   assign req_sel = req_tdata[4:2];
   assign vin = req_tdata[20:5];
   always_comb begin
      if (vin > 16'sd1000) clamped = DutyMax;
      else if (vin < -16'sd1000) clamped = DutyMin;
      else clamped = vin[DutyBits-1:0];
   end

   assign pend    = (pos_ff < cnt_ff);
   assign sel_cur = cur_ff[order_ff[pos_ff]];
   assign edge_v  = {mag_of(sel_cur), 6'b0};
   assign safe_v  = tcount_ff + 16'(GuardTicks);

   // output register is free, or its request leaves in this cycle
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid && req_tready) begin
            case (req_op)
               OP_TICK:    state_in = ST_RAMP;
               OP_COMPARE: state_in = ST_CMP;
               default:    state_in = ST_OUT;
            endcase
         end
         ST_RAMP:  if (i_ff == SlotBits'(MotorSlots-1)) state_in = ST_SORT;
         ST_SORT:  if (cnt_ff < 2 || (i_ff >= cnt_ff - 2 && j_ff >= cnt_ff - 1))
                      state_in = ST_SCHED;
         ST_SCHED: state_in = ST_OUT;
         ST_CMP:   state_in = pend ? ST_SCHED : ST_OUT;
         ST_OUT:   if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         bridge_ff    <= '0;
         pwm_ff       <= '0;
         dira_ff      <= '0;
         dirb_ff      <= '0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         cmp_ff       <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         for (int k = 0; k < MotorSlots; k++) begin
            step_ff[k]  <= 8'd1;
            tgt_ff[k]   <= '0;
            cur_ff[k]   <= '0;
            order_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == 3'(CSR_ACTIVE)) active_ff <= csr_wdata[MotorSlots-1:0];
            else if (csr_index == 3'(CSR_BRIDGE)) bridge_ff <= csr_wdata[MotorSlots-1:0];
            else if (csr_index >= 3'd2 && csr_index < 3'(MotorSlots + 2))
               step_ff[csr_index - 3'd2] <= csr_wdata;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               tcount_ff <= req_tdata[36:21];
               upd_ff    <= 1'b0;
               i_ff      <= '0;
               if ((req_op == OP_SET_TARGET || req_op == OP_SET_NOW)
                   && req_sel < 3'(MotorSlots)) begin
                  tgt_ff[req_sel] <= clamped;
                  if (req_op == OP_SET_NOW) begin
                     cur_ff[req_sel] <= clamped;
                     if (bridge_ff[req_sel]) begin
                        dira_ff[req_sel] <= clamped > 0;
                        dirb_ff[req_sel] <= clamped < 0;
                     end
                  end
               end
               if (req_op == OP_TICK) begin
                  cnt_ff <= '0;
                  pos_ff <= '0;
               end
            end
            ST_RAMP: begin
               if (active_ff[i_ff]) begin
                  cur_ff[i_ff] <= rres.cur;
                  if (rres.dir_wr && bridge_ff[i_ff]) begin
                     dira_ff[i_ff] <= rres.dir_a;
                     dirb_ff[i_ff] <= rres.dir_b;
                  end
                  if (rres.cur != '0) pwm_ff[i_ff] <= 1'b1;
                  order_ff[cnt_ff] <= i_ff;
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (i_ff == SlotBits'(MotorSlots-1)) begin
                  i_ff <= '0;
                  j_ff <= 3'd1;
               end else i_ff <= i_ff + 1'b1;
            end
            ST_SORT: begin
               if (cnt_ff >= 2) begin
                  // one compare-exchange a cycle
                  if (mag_of(cur_ff[order_ff[j_ff]]) < mag_of(cur_ff[order_ff[i_ff]])) begin
                     order_ff[i_ff] <= order_ff[j_ff];
                     order_ff[j_ff] <= order_ff[i_ff];
                  end
                  if (j_ff >= cnt_ff - 1) begin
                     i_ff <= i_ff + 1'b1;
                     j_ff <= i_ff + 3'd2;
                  end else j_ff <= j_ff + 1'b1;
               end
               pos_ff <= '0;
            end
            ST_SCHED: if (pend) begin
               cmp_ff <= (edge_v > safe_v) ? edge_v : safe_v;
               upd_ff <= 1'b1;
            end
            ST_CMP: if (pend) begin
               pwm_ff[order_ff[pos_ff]] <= 1'b0;
               pos_ff <= pos_ff + 1'b1;
            end
            ST_OUT: if (rsp_load) rsp_data_ff <= {upd_ff, cmp_ff, dirb_ff, dira_ff, pwm_ff};
            default: ;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= cnt_ff)
      else $error("order position beyond count");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed while waiting");

endmodule

>>> verif/ramped_multichannel_soft_pwm_tb.sv
// testbench for the ramped multichannel soft pwm block: random and directed requests,
// a slot-level predictor and an in-order scoreboard of expected pin states
// depends on rmsp_pkg and the ramped_multichannel_soft_pwm rtl
`timescale 1ns / 100ps
module ramped_multichannel_soft_pwm_tb;
   import rmsp_pkg::*;

   typedef struct packed {
      logic        upd;
      logic [15:0] cmp;
      logic [4:0]  dir_b;
      logic [4:0]  dir_a;
      logic [4:0]  pwm;
   } pin_state_type;

   class pin_scoreboard;
      pin_state_type pending[$];
      int errors = 0;
      function void note_request(pin_state_type p);
         pending.push_back(p);
      endfunction
      function void check_response(logic [31:0] d);
         pin_state_type got, want;
         got = d;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response exp none act %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.pwm !== want.pwm) begin
            $display("%0t: pwm exp %h act %h", $time, want.pwm, got.pwm); errors++;
         end
         if (got.dir_a !== want.dir_a) begin
            $display("%0t: dir_a exp %h act %h", $time, want.dir_a, got.dir_a); errors++;
         end
         if (got.dir_b !== want.dir_b) begin
            $display("%0t: dir_b exp %h act %h", $time, want.dir_b, got.dir_b); errors++;
         end
         if (got.cmp !== want.cmp) begin
            $display("%0t: compare exp %0d act %0d", $time, want.cmp, got.cmp); errors++;
         end
         if (got.upd !== want.upd) begin
            $display("%0t: update exp %b act %b", $time, want.upd, got.upd); errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [39:0] req_tdata;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [7:0]  csr_wdata;

   ramped_multichannel_soft_pwm uut (.*);

   // predictor state
   logic [4:0]  act_bits, bridge_bits;
   logic [7:0]  slew[MotorSlots];
   int          tgt[MotorSlots], cur[MotorSlots];
   int          order[MotorSlots];
   int          n_order, pos;
   logic [4:0]  pwm_q, da_q, db_q;
   logic [15:0] cmp_q;

   pin_scoreboard sb;
   int  cycles = 0;
   bit  hold_off = 0;
   longint limit = 3000000;

   function automatic int absv(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void set_dir(int s, int v);
      if (!bridge_bits[s]) return;
      da_q[s] = v > 0;
      db_q[s] = v < 0;
   endfunction

   function automatic void slew_slot(int s);
      int c, t, st;
      c = cur[s]; t = tgt[s]; st = slew[s];
      if (c == t) return;
      if (bridge_bits[s] && c != 0 && ((c > 0) != (t > 0))) begin
         if (st >= absv(c)) c = 0;
         else c += c > 0 ? -st : st;
         cur[s] = c;
         if (c == 0) set_dir(s, 0);
         return;
      end
      if (c < t) begin c += st; if (c > t) c = t; end
      else begin c -= st; if (c < t) c = t; end
      cur[s] = c;
      set_dir(s, c);
   endfunction

   function automatic bit next_edge(int tc);
      int e, g;
      if (pos >= n_order) return 0;
      e = (absv(cur[order[pos]]) << 6) & 16'hffff;
      g = (tc + GuardTicks) & 16'hffff;
      cmp_q = 16'(e > g ? e : g);
      return 1;
   endfunction

   function automatic pin_state_type predict(op_type op, int sel, logic [15:0] val, int tc);
      int v, t;
      bit u;
      u = 0;
      case (op)
         OP_SET_TARGET, OP_SET_NOW: begin
            if (sel < MotorSlots) begin
               v = $signed(val);
               if (v > 1000) v = 1000;
               if (v < -1000) v = -1000;
               tgt[sel] = v;
               if (op == OP_SET_NOW) begin cur[sel] = v; set_dir(sel, v); end
            end
         end
         OP_TICK: begin
            n_order = 0;
            for (int i = 0; i < MotorSlots; i++) if (act_bits[i]) begin
               slew_slot(i);
               if (cur[i] != 0) pwm_q[i] = 1;
               order[n_order++] = i;
            end
            for (int i = 0; i < n_order; i++)
               for (int j = i + 1; j < n_order; j++)
                  if (absv(cur[order[j]]) < absv(cur[order[i]])) begin
                     t = order[i]; order[i] = order[j]; order[j] = t;
                  end
            pos = 0;
            u = next_edge(tc);
         end
         default: begin
            if (pos < n_order) begin
               pwm_q[order[pos]] = 0;
               pos++;
               u = next_edge(tc);
            end
         end
      endcase
      return '{upd: u, cmp: cmp_q, dir_b: db_q, dir_a: da_q, pwm: pwm_q};
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > limit) begin
         $display("ramped_multichannel_soft_pwm_tb NOT OK");
         $finish;
      end
   end

   // response side: random stalls plus the optional long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 9) < 7) ? 1 :
                         ($urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1)));
   end

   // idle between requests; valid stays up when no gap follows
   task automatic gap();
      int n;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send(op_type op, int sel, logic [15:0] val, logic [15:0] tc);
      req_tvalid <= 1;
      req_tdata  <= {3'b0, tc, val, sel[2:0], op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(predict(op, sel, val, tc));
      gap();
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(int idx, logic [7:0] d);
      req_tvalid <= 0;
      csr_we <= 1; csr_index <= idx[2:0]; csr_wdata <= d;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_ACTIVE) act_bits = d[4:0];
      else if (idx == CSR_BRIDGE) bridge_bits = d[4:0];
      else slew[idx - 2] = d;
      @(posedge clock);
   endtask

   task automatic random_request();
      int r, sel;
      logic [15:0] v;
      r = $urandom_range(0, 99);
      sel = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      case ($urandom_range(0, 3))
         0: v = 16'($urandom);
         1: v = 16'($urandom_range(0, 2000) - 1000);
         2: v = $urandom_range(0, 1) ? 16'd1000 : -16'sd1000;
         default: v = 16'($urandom_range(0, 60) - 30);
      endcase
      if (r < 25) send(OP_SET_TARGET, sel, v, 16'($urandom));
      else if (r < 35) send(OP_SET_NOW, sel, v, 16'($urandom));
      else if (r < 55) send(OP_TICK, $urandom_range(0, 7), 16'($urandom), 16'($urandom));
      else send(OP_COMPARE, $urandom_range(0, 7), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      sb = new();
      reset = 1; req_tvalid = 0; req_tdata = '0; rsp_tready = 0;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      act_bits = 0; bridge_bits = 0;
      for (int i = 0; i < MotorSlots; i++) begin
         slew[i] = 1; tgt[i] = 0; cur[i] = 0; order[i] = 0;
      end
      n_order = 0; pos = 0; pwm_q = 0; da_q = 0; db_q = 0; cmp_q = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, then extremes with all slots bridged
      send(OP_COMPARE, 0, 0, 16'hffff);
      send(OP_TICK, 0, 0, 0);
      drain();
      write_reg(CSR_ACTIVE, 8'h1f);
      write_reg(CSR_BRIDGE, 8'h1f);
      write_reg(2, 200); write_reg(3, 1); write_reg(4, 0); write_reg(5, 255);
      write_reg(6, 100);
      send(OP_SET_TARGET, 0, 16'h7fff, 0);
      send(OP_SET_NOW, 1, 16'h8000, 0);
      send(OP_SET_NOW, 2, 16'd500, 0);
      send(OP_SET_TARGET, 3, -16'sd1000, 0);
      send(OP_SET_NOW, 4, 16'd0, 0);
      send(OP_SET_NOW, 7, 16'd999, 0);
      send(OP_TICK, 0, 0, 16'hffff);
      for (int i = 0; i < 6; i++) send(OP_COMPARE, 0, 0, 16'hff00);
      send(OP_SET_TARGET, 1, 16'd1000, 0);
      send(OP_TICK, 0, 0, 16'd1234);
      send(OP_COMPARE, 0, 0, 16'd0);
      send(OP_SET_NOW, 2, -16'sd1, 0);
      send(OP_TICK, 0, 0, 16'd60000);
      drain();

      // random phases, each under a fresh setting
      for (int ph = 0; ph < 13; ph++) begin
         write_reg(CSR_ACTIVE, ph == 0 ? 8'h00 : (ph == 1 ? 8'h1f : 8'($urandom)));
         write_reg(CSR_BRIDGE, ph == 1 ? 8'h00 : 8'($urandom));
         for (int s = 0; s < MotorSlots; s++)
            write_reg(s + 2, ph == 2 ? 8'd1 : (ph == 3 ? 8'd200 :
                      (ph == 4 ? 8'd255 : 8'($urandom_range(0, 255)))));
         if (ph == 5) fork
            begin
               hold_off = 1;
               repeat (400) @(posedge clock);
               hold_off = 0;
            end
         join_none
         for (int k = 0; k < 150; k++) random_request();
         drain();
      end

      if (sb.errors == 0) $display("ramped_multichannel_soft_pwm_tb OK");
      else $display("ramped_multichannel_soft_pwm_tb NOT OK");
      $finish;
   end
endmodule

>>> ramped_multichannel_soft_pwm.f
rtl/rmsp_pkg.sv
rtl/rmsp_ramp.sv
rtl/ramped_multichannel_soft_pwm.sv
verif/ramped_multichannel_soft_pwm_tb.sv
